@@ rtl/smh_pkg.sv @@
`timescale 1ns / 1ps
// Package for the segment horizontal mirror: widths, register indexes,
// reset values, control state and the cell operation code. No dependencies.
package smh_pkg;

    localparam int DEF_MAX_SEGMENT   = 64;
    localparam int DEF_MAX_ROW_WIDTH = 4096;
    localparam int DEF_PIXEL_BITS    = 32;

    localparam int PIXEL_W       = 32;
    localparam int ROW_WIDTH_W   = 13;
    localparam int SEG_LEN_W     = 7;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LEN = 2'd1;

    localparam logic [ROW_WIDTH_W-1:0] RESET_ROW_WIDTH   = 13'd64;
    localparam logic [SEG_LEN_W-1:0]   RESET_SEGMENT_LEN = 7'd16;

    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } cell_op_t;

endpackage

@@ rtl/smh_cell.sv @@
`timescale 1ns / 1ps
// One cell of the pixel stack: holds one pixel, takes its left neighbor on a
// push and its right neighbor on a pop. Depends on smh_pkg.
module smh_cell
    import smh_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [PIXEL_BITS-1:0] left,
    input  logic [PIXEL_BITS-1:0] right,
    output logic [PIXEL_BITS-1:0] q
);

    logic [PIXEL_BITS-1:0] q_reg;
    logic [PIXEL_BITS-1:0] q_next;

    always_comb
    begin
        case (op)
            CELL_PUSH: q_next = left;
            CELL_POP:  q_next = right;
            default:   q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ rtl/smh_stack.sv @@
`timescale 1ns / 1ps
// Row of stack cells: a push shifts toward the deep end with the new pixel at
// the head, a pop shifts toward the head. Depends on smh_pkg and smh_cell.
module smh_stack
    import smh_pkg::*;
#(
    parameter int MAX_SEGMENT = DEF_MAX_SEGMENT,
    parameter int PIXEL_BITS  = DEF_PIXEL_BITS
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [PIXEL_BITS-1:0] push_data,
    output logic [PIXEL_BITS-1:0] head
);

    logic [PIXEL_BITS-1:0] cell_q [MAX_SEGMENT];

    for (genvar i = 0; i < MAX_SEGMENT; i++)
    begin : g_cell
        logic [PIXEL_BITS-1:0] left;
        logic [PIXEL_BITS-1:0] right;

        if (i == 0)
        begin : g_first
            assign left = push_data;
        end
        else
        begin : g_inner_left
            assign left = cell_q[i-1];
        end

        if (i == MAX_SEGMENT - 1)
        begin : g_last
            assign right = cell_q[i];
        end
        else
        begin : g_inner_right
            assign right = cell_q[i+1];
        end

        smh_cell #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .clk   (clk),
            .op    (op),
            .left  (left),
            .right (right),
            .q     (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

@@ rtl/segment_horizontal_mirror_top.sv @@
`timescale 1ns / 1ps
// Segment horizontal mirror, top level. Depends on smh_pkg and smh_stack.
//
// Pixels arrive in raster order; each row of row_width pixels is cut into
// whole segments of segment_len pixels, and each segment leaves reversed left
// to right. A pixel past the last whole segment of a row passes through and is
// on the output in the cycle after it is accepted, one per cycle while the
// output is not stalled. A segment of S pixels is pushed into a row of stack
// cells at one pixel per cycle while input is offered; once its last pixel
// is pushed, the block pops it through the output register at one pixel per
// cycle while the output is not stalled, and the input is held off while it
// is popped. m_tlast marks the last pixel that one input produced, m_tuser
// marks the last pixel of a row. A write to either register restarts the row
// and drops a partly filled segment.
module segment_horizontal_mirror_top
    import smh_pkg::*;
#(
    parameter int MAX_SEGMENT   = DEF_MAX_SEGMENT,
    parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
    parameter int PIXEL_BITS    = DEF_PIXEL_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,   // pixel_in[31:0]

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [PIXEL_W-1:0]     m_tdata,   // pixel_out[31:0]
    output logic                   m_tlast,   // run_last
    output logic                   m_tuser    // row_end
);

    localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
    localparam int WW     = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
    localparam int SEG_W  = $clog2(MAX_SEGMENT + 1);
    localparam int FILL_W = $clog2(MAX_SEGMENT);

    state_t                 state_reg, state_next;
    logic [ROW_WIDTH_W-1:0] row_width_reg, row_width_next;
    logic [SEG_LEN_W-1:0]   seg_len_reg, seg_len_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [SEG_W-1:0]       emit_cnt_reg, emit_cnt_next;
    logic                   row_end_pend_reg, row_end_pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0]  out_pix_reg, out_pix_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_row_end_reg, out_row_end_next;

    logic [WW-1:0]          eff_w;
    logic [SEG_W-1:0]       eff_s;
    logic [WW-1:0]          col_ext;
    logic [WW-1:0]          col_eff;
    logic [WW:0]            seg_end;
    logic                   last_col;
    logic                   in_zone;
    logic [SEG_W-1:0]       fill_inc;
    logic                   out_free;
    logic                   accept;
    logic [PIXEL_BITS-1:0]  pix;
    cell_op_t               stack_op;
    logic [PIXEL_BITS-1:0]  stack_head;

    smh_stack #(
        .MAX_SEGMENT (MAX_SEGMENT),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_stack (
        .clk       (clk),
        .op        (stack_op),
        .push_data (pix),
        .head      (stack_head)
    );

    // Clamp the registers to their usable ranges.
    always_comb
    begin
        if (row_width_reg == '0)
            eff_w = WW'(1);
        else if (WW'(row_width_reg) > WW'(MAX_ROW_WIDTH))
            eff_w = WW'(MAX_ROW_WIDTH);
        else
            eff_w = WW'(row_width_reg);

        if (seg_len_reg == '0)
            eff_s = SEG_W'(1);
        else if (seg_len_reg > SEG_LEN_W'(MAX_SEGMENT))
            eff_s = SEG_W'(MAX_SEGMENT);
        else
            eff_s = SEG_W'(seg_len_reg);
    end

    assign pix      = s_tdata[PIXEL_BITS-1:0];
    assign col_ext  = WW'(col_reg);
    assign last_col = (col_ext == eff_w - WW'(1));
    assign col_eff  = (col_ext >= eff_w) ? '0 : col_ext;
    // A segment opens only where it still fits whole into the row.
    assign seg_end  = {1'b0, col_eff} + (WW+1)'(eff_s);
    assign in_zone  = (fill_reg != '0) || (seg_end <= {1'b0, eff_w});
    assign fill_inc = SEG_W'(fill_reg) + SEG_W'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_FILL) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next        = state_reg;
        row_width_next    = row_width_reg;
        seg_len_next      = seg_len_reg;
        col_next          = col_reg;
        fill_next         = fill_reg;
        emit_cnt_next     = emit_cnt_reg;
        row_end_pend_next = row_end_pend_reg;
        out_valid_next    = out_free ? 1'b0 : out_valid_reg;
        out_pix_next      = out_pix_reg;
        out_last_next     = out_last_reg;
        out_row_end_next  = out_row_end_reg;
        stack_op          = CELL_HOLD;

        case (state_reg)
            ST_FILL:
            begin
                if (accept)
                begin
                    col_next = last_col ? '0 : COL_W'(col_eff + WW'(1));
                    if (in_zone)
                    begin
                        stack_op = CELL_PUSH;
                        if (fill_inc == eff_s)
                        begin
                            fill_next         = '0;
                            emit_cnt_next     = eff_s;
                            row_end_pend_next = last_col;
                            state_next        = ST_EMIT;
                        end
                        else
                        begin
                            fill_next = FILL_W'(fill_inc);
                        end
                    end
                    else
                    begin
                        fill_next        = '0;
                        out_valid_next   = 1'b1;
                        out_pix_next     = pix;
                        out_last_next    = 1'b1;
                        out_row_end_next = last_col;
                    end
                end
            end
            ST_EMIT:
            begin
                // Pop the head into the output register while it is free.
                if (out_free)
                begin
                    stack_op         = CELL_POP;
                    out_valid_next   = 1'b1;
                    out_pix_next     = stack_head;
                    out_last_next    = (emit_cnt_reg == SEG_W'(1));
                    out_row_end_next = (emit_cnt_reg == SEG_W'(1)) && row_end_pend_reg;
                    emit_cnt_next    = emit_cnt_reg - SEG_W'(1);
                    if (emit_cnt_reg == SEG_W'(1))
                        state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:
                begin
                    row_width_next = cfg_data[ROW_WIDTH_W-1:0];
                    col_next       = '0;
                    fill_next      = '0;
                end
                REG_SEGMENT_LEN:
                begin
                    seg_len_next = cfg_data[SEG_LEN_W-1:0];
                    col_next     = '0;
                    fill_next    = '0;
                end
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FILL;
            row_width_reg    <= RESET_ROW_WIDTH;
            seg_len_reg      <= RESET_SEGMENT_LEN;
            col_reg          <= '0;
            fill_reg         <= '0;
            emit_cnt_reg     <= '0;
            row_end_pend_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_width_reg    <= row_width_next;
            seg_len_reg      <= seg_len_next;
            col_reg          <= col_next;
            fill_reg         <= fill_next;
            emit_cnt_reg     <= emit_cnt_next;
            row_end_pend_reg <= row_end_pend_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pix_reg     <= out_pix_next;
        out_last_reg    <= out_last_next;
        out_row_end_reg <= out_row_end_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = PIXEL_W'(out_pix_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_row_end_reg;

    a_row_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("row end flagged on a pixel that does not close its run");

    a_fill_below_seg: assert property (@(posedge clk) disable iff (!rst_n)
        SEG_W'(fill_reg) < eff_s)
        else $error("fill count reached the segment length");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_ext < eff_w)
        else $error("column counter outside the row");

    a_complete_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_zone && (fill_inc == eff_s) |=> state_reg == ST_EMIT)
        else $error("completed segment did not start draining");

endmodule

@@ verif/segment_horizontal_mirror_top_test.sv @@
`timescale 1ns / 1ps
// Testbench for segment_horizontal_mirror_top: random pixel stream over many row
// and segment settings, checked item by item against an in-bench mirror predictor.
// Depends on smh_pkg and the RTL of the block only.
module segment_horizontal_mirror_top_test;
    import smh_pkg::*;

    localparam int SEG_MAX      = 64;
    localparam int ROW_MAX      = 4096;
    localparam int DRAIN_CYCLES = 2 * SEG_MAX + 24;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               run_last;
        logic               row_end;
    } mirror_px_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ROW_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata = '0;   // pixel_in[31:0]

    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [PIXEL_W-1:0]     m_tdata;        // pixel_out[31:0]
    logic                   m_tlast;        // run_last
    logic                   m_tuser;        // row_end

    // Mirror predictor state
    logic [PIXEL_W-1:0]     seg_pixels [SEG_MAX];
    logic [11:0]            next_col;
    logic [5:0]             seg_fill;
    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic [SEG_LEN_W-1:0]   seg_len_reg;

    logic [PIXEL_W-1:0]     pixels_pending [$];
    mirror_px_t             mirrored_px [$];

    int                     pixels_queued   = 0;
    int                     pixels_accepted = 0;
    int                     px_checked      = 0;
    int                     errors          = 0;
    int                     hold_left       = 0;
    bit                     hold_done       = 1'b0;

    segment_horizontal_mirror_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Push the results one accepted pixel causes onto mirrored_px.
    function automatic void predict_mirror(input logic [PIXEL_W-1:0] pixel);
        int         width;
        int         seg;
        int         limit;
        int         col;
        int         fill;
        bit         last_col;
        mirror_px_t px;
        width = row_width_reg;
        if (width == 0) width = 1;
        if (width > ROW_MAX) width = ROW_MAX;
        seg = seg_len_reg;
        if (seg == 0) seg = 1;
        if (seg > SEG_MAX) seg = SEG_MAX;
        limit = (width / seg) * seg;
        col = next_col;
        last_col = (col == width - 1);
        if (col >= width) col = 0;
        if (col < limit) begin
            fill = seg_fill;
            if (fill >= seg) fill = 0;
            seg_pixels[fill % SEG_MAX] = pixel;
            fill++;
            if (fill == seg) begin
                // segment complete: emit it right to left
                for (int k = 0; k < seg; k++) begin
                    px.pixel    = seg_pixels[(seg - 1 - k) % SEG_MAX];
                    px.run_last = (k == seg - 1);
                    px.row_end  = (k == seg - 1) && last_col;
                    mirrored_px.push_back(px);
                end
                fill = 0;
            end
            seg_fill = fill[5:0];
        end
        else begin
            px.pixel    = pixel;
            px.run_last = 1'b1;
            px.row_end  = last_col;
            mirrored_px.push_back(px);
            seg_fill = '0;
        end
        next_col = last_col ? 12'd0 : 12'(col + 1);
    endfunction

    // Driver: predict on acceptance, then offer the next pending pixel.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin : drive
            bit steady;
            bit idle_in;
            if (s_tvalid && s_tready)
            begin
                predict_mirror(s_tdata);
                pixels_accepted++;
            end
            steady  = (pixels_accepted >= 100) && (pixels_accepted < 150);
            idle_in = ($urandom_range(99) < 14) && !steady;
            if (!s_tvalid || s_tready)
            begin
                if (pixels_pending.size() > 0 && !idle_in)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixels_pending.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random idling, plus one long hold-off to back up the block.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin : ready_gen
            bit steady;
            steady = (pixels_accepted >= 100) && (pixels_accepted < 150);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && pixels_accepted >= 95)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !(($urandom_range(99) < 14) && !steady);
            end
        end
    end

    // Monitor: compare each accepted pixel with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin : check
            mirror_px_t want;
            px_checked++;
            if (mirrored_px.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel %h tlast %b tuser %b",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = mirrored_px.pop_front();
                if (m_tdata !== want.pixel)
                begin
                    errors++;
                    $display("%0t: pixel mismatch: expected %h actual %h",
                             $time, want.pixel, m_tdata);
                end
                if (m_tlast !== want.run_last)
                begin
                    errors++;
                    $display("%0t: tlast mismatch: expected %b actual %b",
                             $time, want.run_last, m_tlast);
                end
                if (m_tuser !== want.row_end)
                begin
                    errors++;
                    $display("%0t: tuser mismatch: expected %b actual %b",
                             $time, want.row_end, m_tuser);
                end
            end
        end
    end

    task automatic wait_quiet();
        while (pixels_accepted != pixels_queued || mirrored_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_ROW_WIDTH)
            row_width_reg = value[ROW_WIDTH_W-1:0];
        else
            seg_len_reg = value[SEG_LEN_W-1:0];
        // a write restarts the row and drops a partial segment
        next_col = '0;
        seg_fill = '0;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int width, input int seg);
        wait_quiet();
        write_reg(REG_ROW_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_SEGMENT_LEN, CFG_DATA_W'(seg));
    endtask

    task automatic queue_pixel(input logic [PIXEL_W-1:0] pixel);
        pixels_pending.push_back(pixel);
        pixels_queued++;
    endtask

    task automatic queue_random(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(15);
            if (pick == 0)
                queue_pixel('0);
            else if (pick == 1)
                queue_pixel('1);
            else
                queue_pixel($urandom);
        end
    endtask

    initial
    begin
        next_col      = '0;
        seg_fill      = '0;
        row_width_reg = RESET_ROW_WIDTH;
        seg_len_reg   = RESET_SEGMENT_LEN;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: segments of 4 in rows of 10, two pass-through pixels per row
        set_geometry(10, 4);
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'h5555_5555);
        queue_pixel(32'hAAAA_AAAA);
        for (int i = 0; i < 8; i++)
            queue_pixel(32'h0100_0000 + i);

        // zero registers act as 1: every pixel is its own segment
        set_geometry(0, 0);
        for (int i = 0; i < 3; i++)
            queue_pixel(32'h0200_0000 + i);

        // oversized registers saturate; leave the segment partly filled
        set_geometry(8191, 127);
        for (int i = 0; i < 5; i++)
            queue_pixel(32'h0300_0000 + i);

        // segment longer than the row: everything passes through
        set_geometry(3, 5);
        for (int i = 0; i < 4; i++)
            queue_pixel(32'h0400_0000 + i);

        // Random phases over a spread of geometries
        set_geometry(64, 64);
        queue_random(64);
        set_geometry(17, 5);
        queue_random(30);
        set_geometry(8, 8);
        queue_random(24);
        set_geometry(6, 7);
        queue_random(10);
        set_geometry(4096, 3);
        queue_random(20);
        set_geometry($urandom_range(1, 40), $urandom_range(0, 20));
        queue_random(15);
        set_geometry($urandom_range(1, 40), $urandom_range(0, 20));
        queue_random(15);

        wait_quiet();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
